// ===== src/tvi_pkg.sv =====
`timescale 1ns / 1ps

package tvi_pkg;

  // Fixed arithmetic format of samples and positions
  localparam int SAMPLE_BITS     = 16;
  localparam int COORD_BITS      = 16;
  localparam int COORD_FRAC_BITS = 8;
  localparam int DIM_BITS        = 7;
  localparam int CELL_BITS       = COORD_BITS - COORD_FRAC_BITS - 1;
  localparam int FRAC_W          = COORD_FRAC_BITS + 1;
  localparam int PAIR_BITS       = 2 * COORD_FRAC_BITS + 1;
  localparam int WEIGHT_BITS     = 3 * COORD_FRAC_BITS + 1;
  localparam int PROD_BITS       = SAMPLE_BITS + WEIGHT_BITS;
  localparam int SUM4_BITS       = PROD_BITS + 2;
  localparam int SUM8_BITS       = PROD_BITS + 3;
  localparam int ADDR_BITS       = 18;
  localparam int AREA_BITS       = 2 * DIM_BITS;
  localparam int NUM_TAPS        = 8;
  localparam int CFG_IDX_BITS    = 2;

  // Item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAGES = 2'd2;

  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WEIGHT_BITS-1:0]        weight_t;
  typedef logic [DIM_BITS-1:0]           dim_t;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic query;
    logic ok;
    logic last;
  } ctl_t;

  // Lower cell and fraction of one axis
  typedef struct packed {
    logic                 ok;
    logic [CELL_BITS-1:0] idx;
    logic [FRAC_W-1:0]    frac;
  } axis_pos_t;

endpackage

// ===== src/tvi_ram.sv =====
`timescale 1ns / 1ps

module tvi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tvi_front.sv =====
`timescale 1ns / 1ps

module tvi_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic                in_last,
  input  tvi_pkg::addr_t      in_addr,
  input  tvi_pkg::sample_t    in_value,
  input  logic [15:0]         in_row,
  input  logic [15:0]         in_col,
  input  logic [15:0]         in_page,
  input  tvi_pkg::dim_t       nr_in,
  input  tvi_pkg::dim_t       nc_in,
  input  tvi_pkg::dim_t       np_in,
  output tvi_pkg::ctl_t       ctl3,
  output tvi_pkg::addr_t      wr_addr3,
  output tvi_pkg::sample_t    wr_value3,
  output tvi_pkg::addr_t      rd_addr [tvi_pkg::NUM_TAPS],
  output tvi_pkg::weight_t    w3 [tvi_pkg::NUM_TAPS]
);
  import tvi_pkg::*;

  localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1 << COORD_FRAC_BITS);

  // Range test and split of one position into cell and fraction
  function automatic axis_pos_t split_axis(logic [COORD_BITS-1:0] p, dim_t dim);
    axis_pos_t                r;
    logic [COORD_BITS-2:0]    mag;
    logic [COORD_BITS-2:0]    upper;
    mag   = p[COORD_BITS-2:0];
    upper = {dim, {COORD_FRAC_BITS{1'b0}}};
    r.ok  = !p[COORD_BITS-1] && (mag >= (COORD_BITS-1)'(ONE)) && (mag <= upper);
    if (mag == upper) begin
      r.idx  = CELL_BITS'(dim) - CELL_BITS'(2);
      r.frac = ONE;
    end else begin
      r.idx  = mag[COORD_BITS-2:COORD_FRAC_BITS] - CELL_BITS'(1);
      r.frac = {1'b0, mag[COORD_FRAC_BITS-1:0]};
    end
    return r;
  endfunction

  axis_pos_t pr, pc, pp;

  assign pr = split_axis(in_row, nr_in);
  assign pc = split_axis(in_col, nc_in);
  assign pp = split_axis(in_page, np_in);

  // Stage 1: positions split, dimensions captured with the item
  ctl_t                 ctl1;
  addr_t                wr_addr1;
  sample_t              wr_value1;
  logic [CELL_BITS-1:0] r1, c1, p1;
  logic [FRAC_W-1:0]    tf1, sf1, wf1;
  dim_t                 nr1, nc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (adv) begin
      ctl1.valid <= in_valid;
      ctl1.query <= (in_op == OP_QUERY);
      ctl1.ok    <= pr.ok && pc.ok && pp.ok;
      ctl1.last  <= in_last;
      wr_addr1   <= in_addr;
      wr_value1  <= in_value;
      r1         <= pr.idx;
      c1         <= pc.idx;
      p1         <= pp.idx;
      tf1        <= pr.frac;
      sf1        <= pc.frac;
      wf1        <= pp.frac;
      nr1        <= nr_in;
      nc1        <= nc_in;
    end
  end

  // Stage 2: column and page offsets, column-page weight pairs
  ctl_t                          ctl2;
  addr_t                         wr_addr2;
  sample_t                       wr_value2;
  logic [CELL_BITS-1:0]          r2;
  logic [CELL_BITS+DIM_BITS-1:0] cnr2, pnr2;
  logic [FRAC_W-1:0]             tf2, tlo2;
  logic [PAIR_BITS-1:0]          cp2 [4];
  dim_t                          nr2, nc2;
  logic [FRAC_W-1:0]             ts1, tw1;

  assign ts1 = ONE - sf1;
  assign tw1 = ONE - wf1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else if (adv) begin
      ctl2      <= ctl1;
      wr_addr2  <= wr_addr1;
      wr_value2 <= wr_value1;
      r2        <= r1;
      cnr2      <= c1 * nr1;
      pnr2      <= p1 * nr1;
      tf2       <= tf1;
      tlo2      <= ONE - tf1;
      cp2[0]    <= PAIR_BITS'(ts1 * tw1);
      cp2[1]    <= PAIR_BITS'(sf1 * tw1);
      cp2[2]    <= PAIR_BITS'(ts1 * wf1);
      cp2[3]    <= PAIR_BITS'(sf1 * wf1);
      nr2       <= nr1;
      nc2       <= nc1;
    end
  end

  // Stage 3: base address, plane area and the eight weights
  localparam int BASE_W = CELL_BITS + DIM_BITS + DIM_BITS + 2;
  logic [BASE_W-1:0]    base_sum;
  addr_t                base3;
  logic [AREA_BITS-1:0] area3;
  dim_t                 nr3;

  assign base_sum = BASE_W'(r2) + BASE_W'(cnr2) + BASE_W'(pnr2 * nc2);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else if (adv) begin
      ctl3      <= ctl2;
      wr_addr3  <= wr_addr2;
      wr_value3 <= wr_value2;
      base3     <= base_sum[ADDR_BITS-1:0];
      area3     <= nr2 * nc2;
      nr3       <= nr2;
      for (int i = 0; i < NUM_TAPS; i++) begin
        w3[i] <= WEIGHT_BITS'((i[0] ? tf2 : tlo2) * cp2[i >> 1]);
      end
    end
  end

  // Neighbor addresses wrap at the store depth
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      rd_addr[i] = base3 + (i[0] ? ADDR_BITS'(1) : '0)
                         + (i[1] ? ADDR_BITS'(nr3) : '0)
                         + (i[2] ? ADDR_BITS'(area3) : '0);
    end
  end

endmodule

// ===== src/tvi_accum.sv =====
`timescale 1ns / 1ps

module tvi_accum (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  tvi_pkg::ctl_t    ctl3,
  input  tvi_pkg::weight_t w3 [tvi_pkg::NUM_TAPS],
  input  tvi_pkg::sample_t rd_data [tvi_pkg::NUM_TAPS],
  output logic             out_valid,
  output tvi_pkg::sample_t out_value,
  output logic             out_oor,
  output logic             out_last
);
  import tvi_pkg::*;

  localparam int SH = 3 * COORD_FRAC_BITS;
  localparam logic signed [SUM8_BITS-1:0] HALF = SUM8_BITS'(1) <<< (SH - 1);
  localparam logic signed [SUM8_BITS-SH-1:0] SMAX = (SUM8_BITS-SH)'((1 << (SAMPLE_BITS-1)) - 1);
  localparam logic signed [SUM8_BITS-SH-1:0] SMIN = -SMAX - (SUM8_BITS-SH)'(1);

  // Stage 4: weights line up with the registered memory data
  ctl_t    ctl4;
  weight_t w4 [NUM_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4.valid <= 1'b0;
    end else if (adv) begin
      ctl4 <= ctl3;
      w4   <= w3;
    end
  end

  // Stage 5: eight products
  ctl_t                        ctl5;
  logic signed [PROD_BITS-1:0] prod5 [NUM_TAPS];
  logic signed [PROD_BITS:0]   prod_full [NUM_TAPS];

  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      prod_full[i] = rd_data[i] * $signed({1'b0, w4[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5.valid <= 1'b0;
    end else if (adv) begin
      ctl5 <= ctl4;
      for (int i = 0; i < NUM_TAPS; i++) begin
        prod5[i] <= prod_full[i][PROD_BITS-1:0];
      end
    end
  end

  // Stage 6: two partial sums of four
  ctl_t                        ctl6;
  logic signed [SUM4_BITS-1:0] part6 [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl6.valid <= 1'b0;
    end else if (adv) begin
      ctl6 <= ctl5;
      for (int k = 0; k < 2; k++) begin
        part6[k] <= SUM4_BITS'(prod5[4*k]) + SUM4_BITS'(prod5[4*k+1])
                  + SUM4_BITS'(prod5[4*k+2]) + SUM4_BITS'(prod5[4*k+3]);
      end
    end
  end

  // Final sum, round half up, saturate
  logic signed [SUM8_BITS-1:0]    total;
  logic signed [SUM8_BITS-1:0]    rounded;
  logic signed [SUM8_BITS-SH-1:0] q;
  sample_t                        sat;

  always_comb begin
    total   = SUM8_BITS'(part6[0]) + SUM8_BITS'(part6[1]);
    rounded = total + HALF;
    q       = rounded[SUM8_BITS-1:SH];
    if (q > SMAX) begin
      sat = SAMPLE_BITS'(SMAX);
    end else if (q < SMIN) begin
      sat = SAMPLE_BITS'(SMIN);
    end else begin
      sat = q[SAMPLE_BITS-1:0];
    end
  end

  // Stage 7: output register, only queries leave a word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl6.valid && ctl6.query;
      out_value <= ctl6.ok ? sat : '0;
      out_oor   <= !ctl6.ok;
      out_last  <= ctl6.last;
    end
  end

endmodule

// ===== src/trilinear_volume_interpolator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Carries
// s_axis    in         tdata voxel_addr/value and row/col/page Q8.8, tuser op, tlast
// m_axis    out        tdata interp_value, tuser out_of_range, tlast last_result
// cfg       in         cfg_we, cfg_index, cfg_data: num_rows, num_cols, num_pages
//
// One word is accepted every cycle unless the output stalls; a query result
// passes the front stages, memory read, products and sums to the output register.
// Write words take the same path, are stored in the third stage, leave no result.
// The eight neighbors come from eight copies of the volume memory, each with
// its own read port. Reset clears valid bits and sets all dimensions to 64.
// A held output stalls the whole pipeline; nothing is lost or repeated.

module trilinear_volume_interpolator #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_PAGES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [17:0] voxel_addr, [33:18] voxel_value, [49:34] row_coord,
  // [65:50] col_coord, [81:66] page_coord, [87:82] zero
  input  logic [87:0]                       s_axis_tdata,
  // [0] operation
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] interp_value
  output logic [15:0]                       m_axis_tdata,
  // [0] out_of_range
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [tvi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tvi_pkg::DIM_BITS-1:0]      cfg_data
);
  import tvi_pkg::*;

  localparam int ROWS_CAP  = (MAX_ROWS  < 127) ? MAX_ROWS  : 127;
  localparam int COLS_CAP  = (MAX_COLS  < 127) ? MAX_COLS  : 127;
  localparam int PAGES_CAP = (MAX_PAGES < 127) ? MAX_PAGES : 127;

  // Configuration registers
  dim_t num_rows, num_cols, num_pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= DIM_BITS'(64);
      num_cols  <= DIM_BITS'(64);
      num_pages <= DIM_BITS'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:  num_rows  <= cfg_data;
        REG_COLS:  num_cols  <= cfg_data;
        REG_PAGES: num_pages <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions held to the supported range
  function automatic dim_t clamp_dim(dim_t v, dim_t cap);
    dim_t r;
    if (v < DIM_BITS'(2)) begin
      r = DIM_BITS'(2);
    end else if (v > cap) begin
      r = cap;
    end else begin
      r = v;
    end
    return r;
  endfunction

  dim_t nr, nc, np;

  assign nr = clamp_dim(num_rows,  DIM_BITS'(ROWS_CAP));
  assign nc = clamp_dim(num_cols,  DIM_BITS'(COLS_CAP));
  assign np = clamp_dim(num_pages, DIM_BITS'(PAGES_CAP));

  // Whole pipeline moves when the output register can take a word
  logic adv;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  ctl_t    ctl3;
  addr_t   wr_addr3;
  sample_t wr_value3;
  addr_t   rd_addr [NUM_TAPS];
  weight_t w3 [NUM_TAPS];
  sample_t rd_data [NUM_TAPS];
  logic    ram_we;

  tvi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .in_addr  (s_axis_tdata[17:0]),
    .in_value (s_axis_tdata[33:18]),
    .in_row   (s_axis_tdata[49:34]),
    .in_col   (s_axis_tdata[65:50]),
    .in_page  (s_axis_tdata[81:66]),
    .nr_in    (nr),
    .nc_in    (nc),
    .np_in    (np),
    .ctl3     (ctl3),
    .wr_addr3 (wr_addr3),
    .wr_value3(wr_value3),
    .rd_addr  (rd_addr),
    .w3       (w3)
  );

  // Volume copies, all written together
  assign ram_we = adv && ctl3.valid && !ctl3.query;

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_bank
    tvi_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(1 << ADDR_BITS)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we),
      .waddr(wr_addr3),
      .wdata(wr_value3),
      .re   (adv),
      .raddr(rd_addr[g]),
      .rdata(rd_data[g])
    );
  end

  tvi_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .ctl3     (ctl3),
    .w3       (w3),
    .rd_data  (rd_data),
    .out_valid(m_axis_tvalid),
    .out_value(m_axis_tdata),
    .out_oor  (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

  // An out-of-range result always carries zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out-of-range word with nonzero value");

  // Memory read data holds while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(rd_data[0]))
    else $error("read data changed during stall");

  // Neighbor addresses hold while the pipeline is stalled
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(rd_addr[7]))
    else $error("read address changed during stall");

endmodule
